### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the port checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge while reset is released.
`define FQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define FQ_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fqks_pkg.sv
// ----------------------------------------------------------------------------
// fqks_pkg
// Types and constants of the FIFO queue with key search.
// ----------------------------------------------------------------------------
package fqks_pkg;

    localparam int HEIGHT_W    = 9;
    localparam int POS_W       = 8;
    localparam int LIMIT_W     = 8;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Status part of one result.
    typedef struct packed {
        t_status              status;
        logic [POS_W-1:0]     position;
        logic [POS_W-1:0]     remaining;
    } t_res_ctl;

endpackage

### rtl/fifo_queue_with_key_search.sv
// Path: push and an unknown request kind go from acceptance straight to the result state and then
// to the output register; a search or a remove first walks the ring from the head to a match or its end.
// Throughput: one request at a time; tready stays low until the result is handed on, since
// the walk reads the storage ring through its single read port, one entry per cycle.
// Reset (synchronous, active low) empties the queue and sets queue_limit to 128;
// the storage ring itself is not cleared.
// ----------------------------------------------------------------------------
// fifo_queue_with_key_search
// Bounded FIFO of key/height records with push, height search and
// remove-through-key, plus the limit register and the output register.
// ----------------------------------------------------------------------------
module fifo_queue_with_key_search #(
    parameter int QUEUE_DEPTH = 128,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    // Configuration: queue_limit.
    input  logic                                              i_cfg_valid,
    output logic                                              o_cfg_ready,
    input  logic [fqks_pkg::LIMIT_W-1:0]                      i_cfg_data,
    // Requests.
    input  logic                                              s_axis_tvalid,
    output logic                                              s_axis_tready,
    // tdata from bit 0: item_id, height, zero fill.
    input  logic [((KEY_WIDTH+fqks_pkg::HEIGHT_W+7)/8)*8-1:0] s_axis_tdata,
    // tuser: req_type.
    input  logic [fqks_pkg::REQ_W-1:0]                        s_axis_tuser,
    // Results.
    output logic                                              m_axis_tvalid,
    input  logic                                              m_axis_tready,
    // tdata from bit 0: position, found_id, found_height, remaining, zero fill.
    output logic [((2*fqks_pkg::POS_W+KEY_WIDTH+fqks_pkg::HEIGHT_W+7)/8)*8-1:0] m_axis_tdata,
    // tuser: status.
    output logic [fqks_pkg::STATUS_W-1:0]                     m_axis_tuser
);
    import fqks_pkg::*;

    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int OUT_W = ((2 * POS_W + KEY_WIDTH + HEIGHT_W + 7) / 8) * 8;
    localparam int RES_W = 2 * POS_W + KEY_WIDTH + HEIGHT_W;

    logic [LIMIT_W-1:0]   r_limit;
    logic [CW-1:0]        eff_limit;
    logic                 res_valid;
    logic                 res_ready;
    t_res_ctl             res_ctl;
    logic [KEY_WIDTH-1:0] res_id;
    logic [HEIGHT_W-1:0]  res_height;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [RES_W-1:0]     r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // The limit in force never exceeds the storage depth.
    assign eff_limit = (LW'(r_limit) >= LW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(r_limit);

    fqks_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req_type   (t_req'(s_axis_tuser)),
        .i_item_id    (s_axis_tdata[KEY_WIDTH-1:0]),
        .i_height     (s_axis_tdata[KEY_WIDTH +: HEIGHT_W]),
        .i_limit      (eff_limit),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res_ctl    (res_ctl),
        .o_res_id     (res_id),
        .o_res_height (res_height)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out_status <= res_ctl.status;
                r_out_data   <= {res_ctl.remaining, res_height, res_id, res_ctl.position};
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = OUT_W'(r_out_data);

endmodule

### rtl/fqks_mem.sv
// ----------------------------------------------------------------------------
// fqks_mem
// Record storage ring: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module fqks_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 41
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fqks_ctrl.sv
// ----------------------------------------------------------------------------
// fqks_ctrl
// Request sequencer: ring pointers, push, and the one-entry-per-cycle walk
// with a shared key/height comparator.
// ----------------------------------------------------------------------------
module fqks_ctrl #(
    parameter int QUEUE_DEPTH = 128,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    output logic                               o_req_ready,
    input  fqks_pkg::t_req                     i_req_type,
    input  logic [KEY_WIDTH-1:0]               i_item_id,
    input  logic [fqks_pkg::HEIGHT_W-1:0]      i_height,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_limit,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output fqks_pkg::t_res_ctl                 o_res_ctl,
    output logic [KEY_WIDTH-1:0]               o_res_id,
    output logic [fqks_pkg::HEIGHT_W-1:0]      o_res_height
);
    import fqks_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int RW = KEY_WIDTH + HEIGHT_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state               r_state;
    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_occ;
    logic [CW-1:0]        r_k;
    logic [CW-1:0]        r_cmp_idx;
    logic                 r_cmp_valid;
    t_req                 r_mode;
    logic [KEY_WIDTH-1:0] r_key;
    logic [HEIGHT_W-1:0]  r_height;
    t_status              r_status;
    logic [CW-1:0]        r_pos;
    logic [KEY_WIDTH-1:0] r_fid;
    logic [HEIGHT_W-1:0]  r_fh;

    logic                 mem_we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        new_head;
    logic [RW-1:0]        rdata;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [HEIGHT_W-1:0]  rd_height;
    logic                 hit;
    logic                 accept;

    // Ring slot that stands off places behind base; the sum stays below twice the depth.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign accept   = i_req_valid && (r_state == S_IDLE);
    assign mem_we   = accept && (i_req_type == REQ_PUSH) && (r_occ < i_limit);
    assign waddr    = slot(r_head, r_occ);
    assign raddr    = slot(r_head, r_k);
    assign new_head = slot(r_head, r_cmp_idx + CW'(1));

    assign rd_key    = rdata[RW-1:HEIGHT_W];
    assign rd_height = rdata[HEIGHT_W-1:0];
    // Shared comparator: the request kind picks which field is matched.
    assign hit = r_cmp_valid &&
                 ((r_mode == REQ_SEARCH) ? (rd_height == r_height) : (rd_key == r_key));

    fqks_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (RW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata ({i_item_id, i_height}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pos       <= '0;
                        r_fid       <= '0;
                        r_fh        <= '0;
                        r_k         <= '0;
                        r_cmp_valid <= 1'b0;
                        r_mode      <= i_req_type;
                        r_key       <= i_item_id;
                        r_height    <= i_height;
                        case (i_req_type)
                            REQ_PUSH: begin
                                if (r_occ >= i_limit) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_pos    <= r_occ;
                                    r_occ    <= r_occ + CW'(1);
                                end
                                r_state <= S_DONE;
                            end
                            REQ_SEARCH, REQ_REMOVE: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Each cycle compares the entry read last cycle and reads the next.
                    if (hit) begin
                        r_status <= ST_DONE;
                        if (r_mode == REQ_SEARCH) begin
                            r_fid <= rd_key;
                            r_fh  <= rd_height;
                        end else begin
                            r_pos  <= r_cmp_idx;
                            r_head <= new_head;
                            r_occ  <= r_occ - r_cmp_idx - CW'(1);
                        end
                        r_state <= S_DONE;
                    end else if (r_k < r_occ) begin
                        r_cmp_idx   <= r_k;
                        r_cmp_valid <= 1'b1;
                        r_k         <= r_k + CW'(1);
                    end else begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready          = (r_state == S_IDLE);
    assign o_res_valid          = (r_state == S_DONE);
    assign o_res_ctl.status     = r_status;
    assign o_res_ctl.position   = POS_W'(r_pos);
    assign o_res_ctl.remaining  = POS_W'(r_occ);
    assign o_res_id             = r_fid;
    assign o_res_height         = r_fh;

endmodule

### rtl/fqks_checker.sv
// ----------------------------------------------------------------------------
// fqks_port_checks
// Port-level checks of the FIFO queue with key search, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fqks_port_checks #(
    parameter int KEY_WIDTH = 32
) (
    input logic                                              i_clk,
    input logic                                              i_rst_n,
    input logic                                              s_axis_tvalid,
    input logic                                              s_axis_tready,
    input logic                                              m_axis_tvalid,
    input logic                                              m_axis_tready,
    input logic [((2*fqks_pkg::POS_W+KEY_WIDTH+fqks_pkg::HEIGHT_W+7)/8)*8-1:0] m_axis_tdata,
    input logic [fqks_pkg::STATUS_W-1:0]                     m_axis_tuser
);
    import fqks_pkg::*;

    localparam int FH_LO = POS_W + KEY_WIDTH;

    // A request keeps the block busy for at least the following cycle.
    `FQ_ASSERT(a_busy_after_req, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "block ready right after taking a request")

    // A result waiting for the sink holds.
    `FQ_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

    // A refused push or a miss carries no position and no found record.
    `FQ_ASSERT(a_empty_fields, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_NOT_FOUND)) |-> (m_axis_tdata[FH_LO-1:0] == '0 && m_axis_tdata[FH_LO +: HEIGHT_W] == '0), "nonzero fields on refused or missed request")

    // Reset leaves no result pending.
    `FQ_ASSERT_ALL(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid, "result pending after reset")

endmodule

bind fifo_queue_with_key_search fqks_port_checks #(
    .KEY_WIDTH (KEY_WIDTH)
) u_fqks_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### verif/fqks_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fqks_checker
// Watches the configuration, request and result channels of the key-search
// queue, keeps its own copy of the record ring to predict every reply, and
// compares each reply field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fqks_checker
    import fqks_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128,
    parameter int KEY_WIDTH   = 32,
    parameter int REQ_DATA_W  = ((KEY_WIDTH + HEIGHT_W + 7) / 8) * 8,
    parameter int RES_DATA_W  = ((2 * POS_W + KEY_WIDTH + HEIGHT_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [LIMIT_W-1:0]    i_cfg_data,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    // From bit 0: item_id, height, zero fill.
    input  logic [REQ_DATA_W-1:0] i_req_data,
    // req_type.
    input  logic [REQ_W-1:0]      i_req_kind,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    // From bit 0: position, found_id, found_height, remaining, zero fill.
    input  logic [RES_DATA_W-1:0] i_res_data,
    // status.
    input  logic [STATUS_W-1:0]   i_res_status,
    input  logic                  i_end_of_test,
    output int                    o_fail_count
);

    typedef struct packed {
        t_status               status;
        logic [POS_W-1:0]      position;
        logic [KEY_WIDTH-1:0]  found_id;
        logic [HEIGHT_W-1:0]   found_height;
        logic [POS_W-1:0]      remaining;
    } t_queue_reply;

    logic [KEY_WIDTH-1:0] ring_key    [QUEUE_DEPTH];
    logic [HEIGHT_W-1:0]  ring_height [QUEUE_DEPTH];
    int                   head_slot;
    int                   held_count;
    logic [LIMIT_W-1:0]   queue_limit;
    t_queue_reply         pending_replies [$];
    int                   n_fail;

    assign o_fail_count = n_fail;

    // Applies one request to the shadow queue and returns the reply it must give.
    function automatic t_queue_reply queue_reply_for(input logic [REQ_W-1:0] kind,
                                                     input logic [KEY_WIDTH-1:0] key,
                                                     input logic [HEIGHT_W-1:0] height);
        t_queue_reply r;
        int           cap;
        int           slot;
        r = '0;
        r.status = ST_NOT_FOUND;
        cap = (queue_limit < QUEUE_DEPTH) ? int'(queue_limit) : QUEUE_DEPTH;
        case (kind)
            REQ_PUSH: begin
                if (held_count >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    slot = (head_slot + held_count) % QUEUE_DEPTH;
                    ring_key[slot] = key;
                    ring_height[slot] = height;
                    r.position = POS_W'(held_count);
                    held_count++;
                    r.status = ST_DONE;
                end
            end
            REQ_SEARCH: begin
                for (int k = 0; k < held_count; k++) begin
                    slot = (head_slot + k) % QUEUE_DEPTH;
                    if (ring_height[slot] == height) begin
                        r.status = ST_DONE;
                        r.found_id = ring_key[slot];
                        r.found_height = ring_height[slot];
                        break;
                    end
                end
            end
            REQ_REMOVE: begin
                for (int k = 0; k < held_count; k++) begin
                    slot = (head_slot + k) % QUEUE_DEPTH;
                    if (ring_key[slot] == key) begin
                        r.status = ST_DONE;
                        r.position = POS_W'(k);
                        head_slot = (slot + 1) % QUEUE_DEPTH;
                        held_count -= k + 1;
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        r.remaining = POS_W'(held_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_queue_reply want;
        t_queue_reply got;
        if (!i_rst_n) begin
            head_slot = 0;
            held_count = 0;
            queue_limit = LIMIT_RESET;
        end else begin
            // A reply always belongs to an earlier request, so it is checked first.
            if (i_res_valid && i_res_ready) begin
                got.status = t_status'(i_res_status);
                got.position = i_res_data[0 +: POS_W];
                got.found_id = i_res_data[POS_W +: KEY_WIDTH];
                got.found_height = i_res_data[POS_W + KEY_WIDTH +: HEIGHT_W];
                got.remaining = i_res_data[POS_W + KEY_WIDTH + HEIGHT_W +: POS_W];
                if (pending_replies.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: reply with no request waiting: status %0d", $realtime,
                                 got.status);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status || got.position !== want.position ||
                        got.found_id !== want.found_id ||
                        got.found_height !== want.found_height ||
                        got.remaining !== want.remaining) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("%0t: reply mismatch", $realtime);
                            $display("  expected status %0d pos %0d id %h height %0d left %0d",
                                     want.status, want.position, want.found_id,
                                     want.found_height, want.remaining);
                            $display("  actual   status %0d pos %0d id %h height %0d left %0d",
                                     got.status, got.position, got.found_id,
                                     got.found_height, got.remaining);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                queue_limit = i_cfg_data;
            if (i_req_valid && i_req_ready)
                pending_replies.push_back(queue_reply_for(i_req_kind,
                                                          i_req_data[0 +: KEY_WIDTH],
                                                          i_req_data[KEY_WIDTH +: HEIGHT_W]));
        end
    end

    always @(posedge i_end_of_test) begin
        if (pending_replies.size() != 0) begin
            $display("%0d replies never arrived", pending_replies.size());
            n_fail += pending_replies.size();
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the key-search queue with directed and random requests under
// random input gaps and output stalls, steps the limit register through
// several values, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import fqks_pkg::*;

    localparam int QUEUE_DEPTH = 128;
    localparam int KEY_WIDTH   = 32;
    localparam int REQ_DATA_W  = ((KEY_WIDTH + HEIGHT_W + 7) / 8) * 8;
    localparam int RES_DATA_W  = ((2 * POS_W + KEY_WIDTH + HEIGHT_W + 7) / 8) * 8;
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int KEY_POOL_N  = 24;
    localparam int HEIGHT_POOL_N = 12;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [LIMIT_W-1:0]    i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [REQ_DATA_W-1:0] s_axis_tdata;
    logic [REQ_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [RES_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  end_of_test;
    int                    fail_count;

    int                    n_sent;
    int                    n_recv;
    int                    kind_count [4];
    int                    limit_writes;
    int                    burst_left;
    int                    stall_cycle;
    int                    stall_mode;
    logic [KEY_WIDTH-1:0]  key_pool [KEY_POOL_N];
    logic [HEIGHT_W-1:0]   height_pool [HEIGHT_POOL_N];
    logic [LIMIT_W-1:0]    limit_plan [N_PHASES] = '{8'd255, 8'd8, 8'd0, 8'd128,
                                                     8'd1, 8'd64, 8'd3, 8'd0};
    int                    push_plan [N_PHASES] = '{70, 50, 50, 45, 60, 40, 55, 60};

    fifo_queue_with_key_search #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fqks_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_kind    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_status  (m_axis_tuser),
        .i_end_of_test (end_of_test),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Timeout with %0d of %0d replies received", n_recv, n_sent);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            n_recv <= n_recv + 1;
    end

    // Result side: the stall pattern is redrawn at random among four modes, and two long
    // holds let the request side back up against a full output register.
    initial begin
        m_axis_tready = 1'b0;
        stall_cycle = 0;
        stall_mode = 0;
        forever begin
            @(negedge i_clk);
            stall_cycle++;
            if (stall_cycle % 256 == 0)
                stall_mode = $urandom_range(0, 3);
            if ((stall_cycle >= 2500 && stall_cycle < 3100) ||
                (stall_cycle >= 30000 && stall_cycle < 30500)) begin
                m_axis_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (stall_cycle % 3 == 0);
                endcase
            end
        end
    end

    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [KEY_WIDTH-1:0] key,
                            input logic [HEIGHT_W-1:0] height);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(REQ_DATA_W - KEY_WIDTH - HEIGHT_W){1'b0}}, height, key};
        s_axis_tuser <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        kind_count[kind]++;
    endtask

    // Every request gives one reply, so the block is idle once the counts agree.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (n_recv != n_sent) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    task automatic send_random(input int push_pct);
        int                   roll;
        logic [REQ_W-1:0]     kind;
        logic [KEY_WIDTH-1:0] key;
        logic [HEIGHT_W-1:0]  height;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            kind = REQ_PUSH;
        else if (roll < push_pct + (100 - push_pct) / 2)
            kind = REQ_REMOVE;
        else if (roll < 96)
            kind = REQ_SEARCH;
        else
            kind = REQ_RESERVED;
        // Most keys and heights come from small pools so that searches and removes hit.
        if ($urandom_range(0, 3) != 0)
            key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        else
            key = $urandom;
        if ($urandom_range(0, 4) < 3)
            height = height_pool[$urandom_range(0, HEIGHT_POOL_N - 1)];
        else
            height = $urandom_range(0, 511);
        send_req(kind, key, height);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_PUSH;
        end_of_test = 1'b0;
        n_sent = 0;
        n_recv = 0;
        limit_writes = 0;
        burst_left = 0;
        kind_count = '{0, 0, 0, 0};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_N; i++)
            key_pool[i] = $urandom;
        height_pool[0] = 9'd0;
        height_pool[1] = 9'd500;
        for (int i = 2; i < HEIGHT_POOL_N; i++)
            height_pool[i] = $urandom_range(0, 500);
        limit_plan[2] = $urandom_range(2, 255);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset limit: empty queue, reserved kind, field extremes.
        send_req(REQ_SEARCH, 32'h0, 9'd0);
        send_req(REQ_REMOVE, 32'h0, 9'd0);
        send_req(REQ_RESERVED, 32'hFFFF_FFFF, 9'd511);
        send_req(REQ_PUSH, 32'h0000_0000, 9'd0);
        send_req(REQ_PUSH, 32'hFFFF_FFFF, 9'd500);
        send_req(REQ_PUSH, 32'hA5A5_5A5A, 9'd511);
        send_req(REQ_PUSH, 32'h5A5A_A5A5, 9'd256);
        send_req(REQ_PUSH, 32'hA5A5_5A5A, 9'd255);
        send_req(REQ_SEARCH, 32'h0, 9'd500);
        send_req(REQ_SEARCH, 32'h0, 9'd511);
        send_req(REQ_SEARCH, 32'h0, 9'd123);
        send_req(REQ_SEARCH, 32'h0, 9'd255);
        send_req(REQ_REMOVE, 32'h1234_5678, 9'd0);
        send_req(REQ_RESERVED, 32'h0, 9'd0);
        send_req(REQ_REMOVE, 32'hA5A5_5A5A, 9'd0);
        send_req(REQ_REMOVE, 32'hA5A5_5A5A, 9'd0);

        // Tiny limit: fill, refuse, then lower the limit under the occupancy.
        write_limit(8'd2);
        send_req(REQ_PUSH, 32'hFFFF_FFFF, 9'd1);
        send_req(REQ_PUSH, 32'h0000_0000, 9'd2);
        send_req(REQ_PUSH, 32'h5A5A_A5A5, 9'd3);
        write_limit(8'd1);
        send_req(REQ_PUSH, 32'h5A5A_A5A5, 9'd4);
        send_req(REQ_REMOVE, 32'hFFFF_FFFF, 9'd0);
        send_req(REQ_PUSH, 32'h5A5A_A5A5, 9'd5);
        send_req(REQ_REMOVE, 32'h0000_0000, 9'd0);
        send_req(REQ_PUSH, 32'h5A5A_A5A5, 9'd6);
        write_limit(8'd0);
        send_req(REQ_PUSH, 32'h1, 9'd7);
        send_req(REQ_REMOVE, 32'h5A5A_A5A5, 9'd0);

        // Random phases; the first one fills the whole ring before mixing kinds.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_limit(limit_plan[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random((ph == 0 && n < 132) ? 100 : push_plan[ph]);
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        end_of_test <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        $display("Covered %0d requests: %0d push, %0d search, %0d remove, %0d reserved kind,",
                 n_sent, kind_count[REQ_PUSH], kind_count[REQ_SEARCH],
                 kind_count[REQ_REMOVE], kind_count[REQ_RESERVED]);
        $display("over %0d limit settings from 0 to 255, with long output stalls.",
                 limit_writes);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/fqks_pkg.sv
rtl/fqks_mem.sv
rtl/fqks_ctrl.sv
rtl/fifo_queue_with_key_search.sv
rtl/fqks_checker.sv
verif/fqks_checker.sv
verif/tb_top.sv
